@@ hw/rtl/ssodo_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths, constants and the arctangent table of the skid-steer odometry block.
// Used by ssodo_mul, ssodo_cordic and the top level. It depends on nothing else.
package ssodo_pkg;

  localparam int unsigned CountW   = 16;
  localparam int unsigned WheelW   = 17;
  localparam int unsigned SumW     = 19;
  localparam int unsigned RegW     = 32;
  localparam int unsigned PosW     = 32;
  localparam int unsigned FwdW     = 34;
  localparam int unsigned MulAW    = 34;
  localparam int unsigned MulBW    = 17;
  localparam int unsigned MulPW    = MulAW + MulBW;
  localparam int unsigned AccW     = 64;
  localparam int unsigned ZW       = 33;
  localparam int unsigned AtanW    = 30;
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 96;

  localparam int unsigned CordicStepsDef = 24;

  localparam logic [RegW-1:0] DistPerCountRst = 32'd1574176;
  localparam logic [RegW-1:0] TurnPerCountRst = 32'd1043900;

  localparam logic signed [PosW-1:0] CordicGain = 32'sd652032874;
  localparam logic signed [PosW-1:0] PosMax     = 32'sh7fff_ffff;
  localparam logic signed [PosW-1:0] PosMin     = 32'sh8000_0000;

  localparam logic CfgDistPerCount = 1'b0;
  localparam logic CfgTurnPerCount = 1'b1;

  function automatic logic [AtanW-1:0] atan_lookup(input logic [4:0] idx);
    logic [AtanW-1:0] v;
    case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335086;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/ssodo_mul.sv @@
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product, used for every partial product.
// Depends on ssodo_pkg for the operand and product widths.
module ssodo_mul (
  input  logic                                 clk_i,
  input  logic signed [ssodo_pkg::MulAW-1:0]   a_i,
  input  logic signed [ssodo_pkg::MulBW-1:0]   b_i,
  output logic signed [ssodo_pkg::MulPW-1:0]   p_o
);
  import ssodo_pkg::*;

  logic signed [MulPW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= MulPW'(a_i) * MulPW'(b_i);
  end

  assign p_o = p_q;

endmodule

@@ hw/rtl/ssodo_cordic.sv @@
`timescale 1ns / 1ps
// Iterative rotation-mode CORDIC giving cosine and sine in Q2.30 of a 32-bit binary angle.
// Depends on ssodo_pkg for widths, the gain constant and the arctangent table.
module ssodo_cordic #(
  parameter int unsigned CORDIC_STEPS = ssodo_pkg::CordicStepsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [ssodo_pkg::RegW-1:0]           angle_i,
  output logic                                 done_o,
  output logic signed [ssodo_pkg::PosW-1:0]    cos_o,
  output logic signed [ssodo_pkg::PosW-1:0]    sin_o
);
  import ssodo_pkg::*;

  localparam int unsigned IterW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [IterW-1:0] IterLast = IterW'(CORDIC_STEPS - 1);

  typedef enum logic {
    C_IDLE,
    C_RUN
  } cstate_e;

  cstate_e                 state_q;
  logic                    done_q;
  logic [IterW-1:0]        iter_q;
  logic                    flip_q;
  logic signed [PosW-1:0]  x_q, x_d;
  logic signed [PosW-1:0]  y_q, y_d;
  logic signed [ZW-1:0]    z_q, z_d;
  logic signed [PosW-1:0]  xs, ys;
  logic signed [ZW-1:0]    atan;
  logic                    flip;
  logic [RegW-1:0]         zfold;

  assign flip  = angle_i[31] ^ angle_i[30];
  assign zfold = {angle_i[31] ^ flip, angle_i[30:0]};

  always_comb begin
    xs   = x_q >>> iter_q;
    ys   = y_q >>> iter_q;
    atan = signed'({3'b000, atan_lookup(5'(iter_q))});
    if (!z_q[ZW-1]) begin
      x_d = x_q - ys;
      y_d = y_q + xs;
      z_d = z_q - atan;
    end else begin
      x_d = x_q + ys;
      y_d = y_q - xs;
      z_d = z_q + atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      done_q  <= 1'b0;
      iter_q  <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        C_IDLE: begin
          if (start_i) begin
            state_q <= C_RUN;
            iter_q  <= '0;
          end
        end
        C_RUN: begin
          iter_q <= iter_q + 1'b1;
          if (iter_q == IterLast) begin
            state_q <= C_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == C_IDLE && start_i) begin
      flip_q <= flip;
      x_q    <= CordicGain;
      y_q    <= '0;
      z_q    <= signed'({zfold[31], zfold});
    end else if (state_q == C_RUN) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign done_o = done_q;
  assign cos_o  = flip_q ? -x_q : x_q;
  assign sin_o  = flip_q ? -y_q : y_q;

endmodule

@@ hw/rtl/skid_steer_odometry_top.sv @@
`timescale 1ns / 1ps
// Top level of the skid-steer odometry block: configuration, pose state and the sequencer.
// Depends on ssodo_pkg, ssodo_mul and ssodo_cordic.
//
//   Channel   Direction   Handshake                          Payload
//   s_axis    in          s_axis_tvalid / s_axis_tready      four counts and direction bits
//   m_axis    out         m_axis_tvalid / m_axis_tready      pos_x, pos_y, heading
//   cfg       in          cfg_valid_i / cfg_ready_o          cfg_index_i, cfg_data_i
//
// From acceptance to result an item runs the CORDIC iterations and the eight partial products of the shared multiplier.
// The input side is not ready while an item is at work; the result waits in an output
// register, and a stalled output holds the next result back in its final step.
// Reset clears the pose and loads the register defaults; no clearing pass is needed.
// The configuration port is always ready.
module skid_steer_odometry_top #(
  parameter int unsigned CORDIC_STEPS = ssodo_pkg::CordicStepsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // count_front_left, dir_front_left, count_front_right, dir_front_right,
  // count_back_left, dir_back_left, count_back_right, dir_back_right, zero pad
  input  logic [ssodo_pkg::InDataW-1:0]     s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // pos_x, pos_y, heading
  output logic [ssodo_pkg::OutDataW-1:0]    m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic                              cfg_index_i,
  input  logic [ssodo_pkg::RegW-1:0]        cfg_data_i
);
  import ssodo_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_LO,
    S_MUL_HI,
    S_MUL_ACC,
    S_FWD,
    S_TURN,
    S_CORDIC,
    S_ROUND,
    S_SAT,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    OP_FWD,
    OP_TURN,
    OP_X,
    OP_Y
  } op_e;

  state_e                   state_q;
  op_e                      op_q;
  logic [RegW-1:0]          dpc_q, tpc_q;
  logic signed [PosW-1:0]   x_q, y_q;
  logic [RegW-1:0]          heading_q;
  logic signed [SumW-1:0]   sum_q, diff_q;
  logic signed [FwdW-1:0]   fwd_q;
  logic signed [FwdW-1:0]   delta_q;
  logic [RegW-1:0]          turn_q;
  logic signed [AccW-1:0]   acc_q;
  logic                     m_valid_q;
  logic [PosW-1:0]          out_x_q, out_y_q, out_h_q;

  logic signed [WheelW-1:0] w_fl, w_fr, w_bl, w_br;
  logic signed [SumW-1:0]   sum_in, diff_in;
  logic signed [MulAW-1:0]  mul_a;
  logic signed [MulBW-1:0]  mul_b;
  logic signed [MulPW-1:0]  mul_p;
  logic signed [AccW-1:0]   p_sx;
  logic signed [AccW-1:0]   rnd_fwd, rnd_pos;
  logic                     hi_half;
  logic [RegW-1:0]          mid;
  logic                     cordic_start, cordic_done;
  logic signed [PosW-1:0]   cos_v, sin_v;
  logic signed [PosW-1:0]   sat_base, sat_val;
  logic signed [PosW+2:0]   sat_sum;
  logic                     in_acc, out_free;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    w_fl = s_axis_tdata[16] ? -WheelW'(s_axis_tdata[15:0])  : WheelW'(s_axis_tdata[15:0]);
    w_fr = s_axis_tdata[33] ? -WheelW'(s_axis_tdata[32:17]) : WheelW'(s_axis_tdata[32:17]);
    w_bl = s_axis_tdata[50] ? -WheelW'(s_axis_tdata[49:34]) : WheelW'(s_axis_tdata[49:34]);
    w_br = s_axis_tdata[67] ? -WheelW'(s_axis_tdata[66:51]) : WheelW'(s_axis_tdata[66:51]);
    sum_in  = SumW'(w_fl) + SumW'(w_fr) + SumW'(w_bl) + SumW'(w_br);
    diff_in = (SumW'(w_fr) + SumW'(w_br)) - (SumW'(w_fl) + SumW'(w_bl));
  end

  assign hi_half = (state_q == S_MUL_HI);

  always_comb begin
    unique case (op_q)
      OP_FWD: begin
        mul_a = MulAW'(sum_q);
        mul_b = hi_half ? signed'({1'b0, dpc_q[31:16]}) : signed'({1'b0, dpc_q[15:0]});
      end
      OP_TURN: begin
        mul_a = MulAW'(diff_q);
        mul_b = hi_half ? signed'({1'b0, tpc_q[31:16]}) : signed'({1'b0, tpc_q[15:0]});
      end
      OP_X: begin
        mul_a = fwd_q;
        mul_b = hi_half ? signed'({cos_v[31], cos_v[31:16]}) : signed'({1'b0, cos_v[15:0]});
      end
      default: begin
        mul_a = fwd_q;
        mul_b = hi_half ? signed'({sin_v[31], sin_v[31:16]}) : signed'({1'b0, sin_v[15:0]});
      end
    endcase
  end

  ssodo_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign p_sx    = AccW'(mul_p);
  assign rnd_fwd = acc_q + 64'sd131072 - signed'({63'd0, acc_q[AccW-1]});
  assign rnd_pos = acc_q + 64'sd536870912 - signed'({63'd0, acc_q[AccW-1]});
  assign mid     = heading_q + acc_q[32:1];

  assign cordic_start = (state_q == S_TURN);

  ssodo_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .angle_i (mid),
    .done_o  (cordic_done),
    .cos_o   (cos_v),
    .sin_o   (sin_v)
  );

  always_comb begin
    sat_base = (op_q == OP_X) ? x_q : y_q;
    sat_sum  = (PosW + 3)'(sat_base) + (PosW + 3)'(delta_q);
    if (sat_sum[PosW+2:PosW-1] == 4'b0000 || sat_sum[PosW+2:PosW-1] == 4'b1111) begin
      sat_val = sat_sum[PosW-1:0];
    end else if (sat_sum[PosW+2]) begin
      sat_val = PosMin;
    end else begin
      sat_val = PosMax;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dpc_q <= DistPerCountRst;
      tpc_q <= TurnPerCountRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgDistPerCount: dpc_q <= cfg_data_i;
        CfgTurnPerCount: tpc_q <= cfg_data_i;
        default:         dpc_q <= dpc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      op_q      <= OP_FWD;
      x_q       <= '0;
      y_q       <= '0;
      heading_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready && state_q != S_DONE) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            op_q    <= OP_FWD;
            state_q <= S_MUL_LO;
          end
        end
        S_MUL_LO:  state_q <= S_MUL_HI;
        S_MUL_HI:  state_q <= S_MUL_ACC;
        S_MUL_ACC: begin
          unique case (op_q)
            OP_FWD:  state_q <= S_FWD;
            OP_TURN: state_q <= S_TURN;
            default: state_q <= S_ROUND;
          endcase
        end
        S_FWD: begin
          op_q    <= OP_TURN;
          state_q <= S_MUL_LO;
        end
        S_TURN:   state_q <= S_CORDIC;
        S_CORDIC: begin
          if (cordic_done) begin
            op_q    <= OP_X;
            state_q <= S_MUL_LO;
          end
        end
        S_ROUND:  state_q <= S_SAT;
        S_SAT: begin
          if (op_q == OP_X) begin
            x_q     <= sat_val;
            op_q    <= OP_Y;
            state_q <= S_MUL_LO;
          end else begin
            y_q       <= sat_val;
            heading_q <= heading_q + turn_q;
            state_q   <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sum_q  <= sum_in;
      diff_q <= diff_in;
    end
    unique case (state_q)
      S_MUL_HI:  acc_q   <= p_sx;
      S_MUL_ACC: acc_q   <= acc_q + signed'({p_sx[AccW-17:0], 16'd0});
      S_FWD:     fwd_q   <= rnd_fwd[51:18];
      S_TURN:    turn_q  <= acc_q[31:0];
      S_ROUND:   delta_q <= rnd_pos[63:30];
      S_DONE: begin
        if (out_free) begin
          out_x_q <= x_q;
          out_y_q <= y_q;
          out_h_q <= heading_q;
        end
      end
      default: acc_q <= acc_q;
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {out_h_q, out_y_q, out_x_q};
  assign cfg_ready_o   = 1'b1;

endmodule

@@ hw/rtl/ssodo_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the skid-steer odometry top level, and the bind that attaches it.
// Depends only on the top level's ports.
module ssodo_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata
);

  logic in_acc;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  a_busy_after_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("Input side ready in the cycle after an item was accepted.");

  a_busy_long : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> ##8 !s_axis_tready)
    else $error("Input side ready again too soon after an item was accepted.");

  a_no_early_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(m_axis_tvalid))
    else $error("Result raised directly after an item was accepted.");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Stalled result item changed or was withdrawn.");

endmodule

bind skid_steer_odometry_top ssodo_checker u_ssodo_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
